>>> hw/rtl/mbtv_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the modbus tcp request validator
// depends on nothing; used by every module of the block

package mbtv_pkg;

  // fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned VerdW  = 4;

  // byte positions inside the frame
  localparam int unsigned IdxTidHi  = 0;
  localparam int unsigned IdxTidLo  = 1;
  localparam int unsigned IdxPidHi  = 2;
  localparam int unsigned IdxPidLo  = 3;
  localparam int unsigned IdxLenHi  = 4;
  localparam int unsigned IdxLenLo  = 5;
  localparam int unsigned IdxUnit   = 6;
  localparam int unsigned IdxCode   = 7;
  localparam int unsigned IdxCntHi  = 10;
  localparam int unsigned IdxCntLo  = 11;
  localparam int unsigned IdxDbc    = 12;

  // frame size checks
  localparam logic [WordW-1:0] MinFrameBytes = 16'd12;
  localparam logic [WordW-1:0] DataOffset    = 16'd13;
  localparam logic [WordW-1:0] HeaderExtra   = 16'd6;
  localparam logic [WordW-1:0] ReadLength    = 16'd6;

  // count limits
  localparam logic [WordW-1:0] MaxBitCount   = 16'd2000;
  localparam logic [WordW-1:0] MaxRegCount   = 16'd125;
  localparam logic [WordW-1:0] MaxCoilValue  = 16'd65280;

  // function codes
  localparam logic [ByteW-1:0] FcReadCoils      = 8'd1;
  localparam logic [ByteW-1:0] FcReadDiscrete   = 8'd2;
  localparam logic [ByteW-1:0] FcReadHolding    = 8'd3;
  localparam logic [ByteW-1:0] FcReadInput      = 8'd4;
  localparam logic [ByteW-1:0] FcWriteCoil      = 8'd5;
  localparam logic [ByteW-1:0] FcWriteRegister  = 8'd6;
  localparam logic [ByteW-1:0] FcWriteCoils     = 8'd15;
  localparam logic [ByteW-1:0] FcWriteRegisters = 8'd16;

  typedef enum logic [VerdW-1:0] {
    VerdOk          = 4'd0,
    VerdParseFail   = 4'd1,
    VerdPduSize     = 4'd2,
    VerdLengthNot6  = 4'd3,
    VerdSizeMismatch = 4'd4,
    VerdCountLimit  = 4'd5,
    VerdByteCount   = 4'd6,
    VerdCoilCount   = 4'd7,
    VerdRegCount    = 4'd8,
    VerdBadCode     = 4'd9
  } verdict_e;

  // one incoming request byte
  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             frame_end;
  } req_t;

  // one result
  typedef struct packed {
    logic [VerdW-1:0] verdict;
    logic [WordW-1:0] transaction_id;
    logic [WordW-1:0] protocol_id;
    logic [WordW-1:0] length_value;
    logic [ByteW-1:0] unit_address;
    logic [ByteW-1:0] func_code;
  } rsp_t;

  // captured frame, handed from front to back
  typedef struct packed {
    logic [WordW-1:0] n_bytes;
    logic [WordW-1:0] transaction_id;
    logic [WordW-1:0] protocol_id;
    logic [WordW-1:0] length_value;
    logic [ByteW-1:0] unit_address;
    logic [ByteW-1:0] func_code;
    logic [WordW-1:0] item_count;
    logic [ByteW-1:0] data_byte_count;
  } frame_t;

endpackage

>>> hw/rtl/mbtv_front.sv
`timescale 1ns / 1ps
// front part: byte counter and header field capture
// depends on mbtv_pkg

module mbtv_front #(
  parameter int unsigned MAX_FRAME_BYTES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  mbtv_pkg::req_t  req_i,
  output logic            frame_valid_o,
  output mbtv_pkg::frame_t frame_o
);
  import mbtv_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] tid_q, tid_d, pid_q, pid_d, len_q, len_d, icnt_q, icnt_d;
  logic [ByteW-1:0] unit_q, unit_d, code_q, code_d, dbc_q, dbc_d;
  logic [ByteW-1:0] b;
  logic             keep;

  assign b    = req_i.frame_byte;
  assign keep = cnt_q < CntW'(MAX_FRAME_BYTES);

  always_comb begin
    cnt_d  = cnt_q;
    tid_d  = tid_q;
    pid_d  = pid_q;
    len_d  = len_q;
    unit_d = unit_q;
    code_d = code_q;
    icnt_d = icnt_q;
    dbc_d  = dbc_q;
    if (keep) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(IdxTidHi) || cnt_q == CntW'(IdxTidLo)) tid_d = {tid_q[ByteW-1:0], b};
      if (cnt_q == CntW'(IdxPidHi) || cnt_q == CntW'(IdxPidLo)) pid_d = {pid_q[ByteW-1:0], b};
      if (cnt_q == CntW'(IdxLenHi) || cnt_q == CntW'(IdxLenLo)) len_d = {len_q[ByteW-1:0], b};
      if (cnt_q == CntW'(IdxUnit)) unit_d = b;
      if (cnt_q == CntW'(IdxCode)) code_d = b;
      if (cnt_q == CntW'(IdxCntHi) || cnt_q == CntW'(IdxCntLo)) icnt_d = {icnt_q[ByteW-1:0], b};
      if (cnt_q == CntW'(IdxDbc)) dbc_d = b;
    end
  end

  always_comb begin
    frame_valid_o           = accept_i && req_i.frame_end;
    frame_o.n_bytes         = WordW'(cnt_d);
    frame_o.transaction_id  = tid_d;
    frame_o.protocol_id     = pid_d;
    frame_o.length_value    = len_d;
    frame_o.unit_address    = unit_d;
    frame_o.func_code       = code_d;
    frame_o.item_count      = icnt_d;
    frame_o.data_byte_count = dbc_d;
  end

  // all capture state clears at the end of every frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      tid_q  <= '0;
      pid_q  <= '0;
      len_q  <= '0;
      unit_q <= '0;
      code_q <= '0;
      icnt_q <= '0;
      dbc_q  <= '0;
    end else if (accept_i) begin
      if (req_i.frame_end) begin
        cnt_q  <= '0;
        tid_q  <= '0;
        pid_q  <= '0;
        len_q  <= '0;
        unit_q <= '0;
        code_q <= '0;
        icnt_q <= '0;
        dbc_q  <= '0;
      end else begin
        cnt_q  <= cnt_d;
        tid_q  <= tid_d;
        pid_q  <= pid_d;
        len_q  <= len_d;
        unit_q <= unit_d;
        code_q <= code_d;
        icnt_q <= icnt_d;
        dbc_q  <= dbc_d;
      end
    end
  end

endmodule

>>> hw/rtl/mbtv_fifo.sv
`timescale 1ns / 1ps
// short queue of captured frames between front and back
// depends on mbtv_pkg

module mbtv_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  mbtv_pkg::frame_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output mbtv_pkg::frame_t rd_data_o
);
  import mbtv_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  frame_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [FillW-1:0]  fill_q;
  logic              do_wr, do_rd;

  assign full_o    = fill_q == FillW'(DEPTH);
  assign valid_o   = fill_q != '0;
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + FillW'(1);
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/mbtv_back.sv
`timescale 1ns / 1ps
// back part: frame checks and the result output register
// depends on mbtv_pkg

module mbtv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_valid_i,
  input  mbtv_pkg::frame_t frame_i,
  output logic             frame_take_o,
  output logic             empty,
  input  logic             pop,
  output mbtv_pkg::rsp_t   result_o
);
  import mbtv_pkg::*;

  logic             out_valid_q;
  rsp_t             out_q;
  verdict_e         verdict;
  logic [WordW-1:0] n, data_len;
  logic [WordW:0]   len_sum;
  logic [ByteW-1:0] code;
  logic             is_read, is_write;

  assign n        = frame_i.n_bytes;
  assign code     = frame_i.func_code;
  assign data_len = n - DataOffset;
  assign len_sum  = {1'b0, frame_i.length_value} + {1'b0, HeaderExtra};
  assign is_read  = code >= FcReadCoils && code <= FcWriteRegister;
  assign is_write = code == FcWriteCoils || code == FcWriteRegisters;

  // checks in priority order
  always_comb begin
    verdict = VerdOk;
    if (n < MinFrameBytes) begin
      verdict = VerdParseFail;
    end else if (is_read) begin
      if (n != MinFrameBytes) begin
        verdict = VerdPduSize;
      end else if (frame_i.length_value != ReadLength) begin
        verdict = VerdLengthNot6;
      end else if ((code == FcReadCoils || code == FcReadDiscrete)
                   && frame_i.item_count > MaxBitCount) begin
        verdict = VerdCountLimit;
      end else if ((code == FcReadHolding || code == FcReadInput)
                   && frame_i.item_count > MaxRegCount) begin
        verdict = VerdCountLimit;
      end else if (code == FcWriteCoil && frame_i.item_count > MaxCoilValue) begin
        verdict = VerdCountLimit;
      end
    end else if (is_write) begin
      if (n == MinFrameBytes) begin
        verdict = VerdPduSize;
      end else if (len_sum != {1'b0, n}) begin
        verdict = VerdSizeMismatch;
      end else if ({{(WordW-ByteW){1'b0}}, frame_i.data_byte_count} != data_len) begin
        verdict = VerdByteCount;
      end else if (code == FcWriteCoils && data_len != frame_i.item_count) begin
        verdict = VerdCoilCount;
      end else if (code == FcWriteRegisters
                   && {1'b0, data_len[WordW-1:1]} != frame_i.item_count) begin
        verdict = VerdRegCount;
      end
    end else begin
      verdict = VerdBadCode;
    end
  end

  assign frame_take_o = frame_valid_i && (!out_valid_q || pop);
  assign empty        = !out_valid_q;
  assign result_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (frame_take_o) begin
      out_q.verdict        <= verdict;
      out_q.transaction_id <= frame_i.transaction_id;
      out_q.protocol_id    <= frame_i.protocol_id;
      out_q.length_value   <= frame_i.length_value;
      out_q.unit_address   <= frame_i.unit_address;
      out_q.func_code      <= frame_i.func_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/modbus_tcp_request_validator.sv
`timescale 1ns / 1ps
// modbus tcp request validator: one byte per cycle in while not full, one verdict per frame out
// the verdict of a frame reaches the result ports through the frame queue and the result register
// one request byte each cycle unless full; a frame may start the cycle after the last one ended
// full only rises when the frame queue is full and the result register is held by the consumer
// reset (rst_ni low, asynchronous) clears byte counter, captured header, queue and result valid
// depends on mbtv_pkg, mbtv_front, mbtv_fifo, mbtv_back

module modbus_tcp_request_validator #(
  parameter int unsigned MAX_FRAME_BYTES = 1024,
  parameter int unsigned QUEUE_DEPTH     = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // request side
  input  logic           push,
  output logic           full,
  input  mbtv_pkg::req_t req_i,
  // result side
  output logic           empty,
  input  logic           pop,
  output mbtv_pkg::rsp_t result_o
);
  import mbtv_pkg::*;

  logic   accept;
  logic   front_valid;
  frame_t front_frame;
  logic   q_full, q_valid, q_take;
  frame_t q_frame;

  // every byte is taken while the frame queue has room; only the last byte
  // of a frame writes the queue, but every byte waits while the queue is full
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: counts bytes, captures header and pdu words, clears on last byte
  mbtv_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (req_i),
    .frame_valid_o(front_valid),
    .frame_o      (front_frame)
  );

  // queue of finished frames so front and back stall independently
  mbtv_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (front_valid),
    .wr_data_i(front_frame),
    .full_o   (q_full),
    .rd_i     (q_take),
    .valid_o  (q_valid),
    .rd_data_o(q_frame)
  );

  // back: runs the checks on the oldest frame and holds the result
  mbtv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_valid_i(q_valid),
    .frame_i      (q_frame),
    .frame_take_o (q_take),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the modbus tcp request validator: queue-driven byte driver,
// result monitor with a built-in frame predictor; depends on mbtv_pkg and the validator rtl

module tb;
  import mbtv_pkg::*;

  localparam int unsigned FrameCap   = 1024;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailPause  = 20;

  // function codes outside the supported set
  localparam logic [ByteW-1:0] FcNone    = 8'd0;
  localparam logic [ByteW-1:0] FcUnknown = 8'd7;
  localparam logic [ByteW-1:0] FcTop     = 8'hFF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  req_t req_i  = '0;
  logic full;
  logic empty;
  rsp_t result_o;

  always #6 clk_i = ~clk_i;

  modbus_tcp_request_validator #(
    .MAX_FRAME_BYTES(FrameCap)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .req_i   (req_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  // request bytes waiting to be offered, and verdicts still owed by the block
  req_t        bytes_to_send[$];
  rsp_t        verdicts_due[$];
  int unsigned queued_bytes  = 0;
  int unsigned queued_frames = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // handshake bookkeeping between the edges
  bit          byte_taken = 1'b0;
  bit          quiet_tail = 1'b0;
  int unsigned tx_gap     = 0;
  int unsigned rx_gap     = 0;
  int unsigned hold_asks  = 0;
  int unsigned hold_done  = 0;
  int unsigned hold_left  = 0;

  // predictor copy of the frame being collected
  int unsigned      kept_bytes = 0;
  logic [WordW-1:0] hdr_tid    = '0;
  logic [WordW-1:0] hdr_pid    = '0;
  logic [WordW-1:0] hdr_len    = '0;
  logic [ByteW-1:0] hdr_unit   = '0;
  logic [ByteW-1:0] hdr_code   = '0;
  logic [WordW-1:0] cnt_word   = '0;
  logic [ByteW-1:0] dbc_byte   = '0;

  // verdict of the collected frame, checks in protocol order
  function automatic verdict_e judge_frame();
    int unsigned data_len;
    if (kept_bytes < MinFrameBytes) return VerdParseFail;
    if (hdr_code >= FcReadCoils && hdr_code <= FcWriteRegister) begin
      if (kept_bytes != MinFrameBytes) return VerdPduSize;
      if (hdr_len != ReadLength) return VerdLengthNot6;
      if ((hdr_code == FcReadCoils || hdr_code == FcReadDiscrete) && cnt_word > MaxBitCount)
        return VerdCountLimit;
      if ((hdr_code == FcReadHolding || hdr_code == FcReadInput) && cnt_word > MaxRegCount)
        return VerdCountLimit;
      if (hdr_code == FcWriteCoil && cnt_word > MaxCoilValue) return VerdCountLimit;
      return VerdOk;
    end
    if (hdr_code == FcWriteCoils || hdr_code == FcWriteRegisters) begin
      if (kept_bytes == MinFrameBytes) return VerdPduSize;
      // 32-bit sum, a length near the top must not wrap
      if (32'(hdr_len) + 32'(HeaderExtra) != kept_bytes) return VerdSizeMismatch;
      data_len = kept_bytes - 32'(DataOffset);
      if (32'(dbc_byte) != data_len) return VerdByteCount;
      // coil writes compare the data byte count itself with the count word
      if (hdr_code == FcWriteCoils && data_len != 32'(cnt_word)) return VerdCoilCount;
      if (hdr_code == FcWriteRegisters && data_len / 2 != 32'(cnt_word)) return VerdRegCount;
      return VerdOk;
    end
    return VerdBadCode;
  endfunction

  // fold one accepted request byte into the frame, emit the verdict on the last one
  function automatic void absorb_byte(input req_t r);
    rsp_t v;
    // bytes past the frame cap are dropped, but their end mark still counts
    if (kept_bytes < FrameCap) begin
      case (kept_bytes)
        IdxTidHi, IdxTidLo: hdr_tid  = {hdr_tid[ByteW-1:0], r.frame_byte};
        IdxPidHi, IdxPidLo: hdr_pid  = {hdr_pid[ByteW-1:0], r.frame_byte};
        IdxLenHi, IdxLenLo: hdr_len  = {hdr_len[ByteW-1:0], r.frame_byte};
        IdxUnit:            hdr_unit = r.frame_byte;
        IdxCode:            hdr_code = r.frame_byte;
        IdxCntHi, IdxCntLo: cnt_word = {cnt_word[ByteW-1:0], r.frame_byte};
        IdxDbc:             dbc_byte = r.frame_byte;
        default: ;
      endcase
      kept_bytes++;
    end
    if (r.frame_end) begin
      v.verdict        = judge_frame();
      v.transaction_id = hdr_tid;
      v.protocol_id    = hdr_pid;
      v.length_value   = hdr_len;
      v.unit_address   = hdr_unit;
      v.func_code      = hdr_code;
      verdicts_due.push_back(v);
      kept_bytes = 0;
      hdr_tid    = '0;
      hdr_pid    = '0;
      hdr_len    = '0;
      hdr_unit   = '0;
      hdr_code   = '0;
      cnt_word   = '0;
      dbc_byte   = '0;
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // queue one frame of total bytes laid out as a request; unused positions are random
  task automatic send_frame(input logic [WordW-1:0] tid, input logic [WordW-1:0] pid,
                            input logic [WordW-1:0] len, input logic [ByteW-1:0] unit,
                            input logic [ByteW-1:0] code, input logic [WordW-1:0] cnt,
                            input logic [ByteW-1:0] dbc, input int unsigned total);
    req_t r;
    for (int unsigned i = 0; i < total; i++) begin
      case (i)
        IdxTidHi: r.frame_byte = tid[15:8];
        IdxTidLo: r.frame_byte = tid[7:0];
        IdxPidHi: r.frame_byte = pid[15:8];
        IdxPidLo: r.frame_byte = pid[7:0];
        IdxLenHi: r.frame_byte = len[15:8];
        IdxLenLo: r.frame_byte = len[7:0];
        IdxUnit:  r.frame_byte = unit;
        IdxCode:  r.frame_byte = code;
        IdxCntHi: r.frame_byte = cnt[15:8];
        IdxCntLo: r.frame_byte = cnt[7:0];
        IdxDbc:   r.frame_byte = dbc;
        default:  r.frame_byte = 8'($urandom);
      endcase
      r.frame_end = (i == total - 1);
      bytes_to_send.push_back(r);
    end
    queued_bytes += total;
    queued_frames++;
  endtask

  // well-formed multiple write with data_n data bytes
  task automatic send_write(input logic [ByteW-1:0] code, input int unsigned data_n);
    logic [WordW-1:0] cnt;
    cnt = (code == FcWriteCoils) ? 16'(data_n) : 16'(data_n / 2);
    send_frame(16'($urandom), 16'd0, 16'(data_n + 7), 8'($urandom), code, cnt,
               8'(data_n), 13 + data_n);
  endtask

  // mostly well-formed requests with random content, the rest broken or plain noise
  task automatic random_request();
    logic [WordW-1:0] tid, pid, len, cnt, lim;
    logic [ByteW-1:0] unit, code, dbc;
    int unsigned      total, data_n, pick;
    tid  = 16'($urandom);
    pid  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
    unit = 8'($urandom);
    dbc  = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // read or single write, count around its limit
      code  = 8'($urandom_range(1, 6));
      len   = ReadLength;
      total = 12;
      case (code)
        FcReadCoils, FcReadDiscrete: lim = MaxBitCount;
        FcReadHolding, FcReadInput:  lim = MaxRegCount;
        FcWriteCoil:                 lim = MaxCoilValue;
        default:                     lim = 16'hFFFF;
      endcase
      case ($urandom_range(0, 3))
        0:       cnt = lim;
        1:       cnt = lim + 16'd1;
        2:       cnt = 16'($urandom_range(0, lim));
        default: cnt = 16'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, 12));
      if ($urandom_range(0, 9) == 0) total = $urandom_range(13, 16);
    end else if (pick < 75) begin
      // multiple write, now and then with one field broken
      code   = $urandom_range(0, 1) ? FcWriteCoils : FcWriteRegisters;
      data_n = $urandom_range(0, 20);
      total  = 13 + data_n;
      len    = 16'(total - 6);
      dbc    = 8'(data_n);
      cnt    = (code == FcWriteCoils) ? 16'(data_n) : 16'(data_n / 2);
      case ($urandom_range(0, 9))
        0:       len = len + 16'($urandom_range(1, 3));
        1:       dbc = dbc ^ (8'd1 << $urandom_range(0, 7));
        2:       cnt = cnt + 16'd1;
        3:       total = 12;
        default: ;
      endcase
    end else begin
      // noise, with a share of frames too short to parse
      code  = 8'($urandom);
      len   = 16'($urandom);
      cnt   = 16'($urandom);
      total = (pick < 90) ? $urandom_range(1, 24) : $urandom_range(1, 11);
    end
    send_frame(tid, pid, len, unit, code, cnt, dbc, total);
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || push || verdicts_due.size() != 0) @(negedge clk_i);
  endtask

  // byte driver: keeps a byte offered until it is taken, random idle bursts between bytes
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push  <= 1'b0;
      req_i <= '0;
    end else if (!push || byte_taken) begin
      byte_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (bytes_to_send.size() != 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 5);
        push <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        req_i <= bytes_to_send.pop_front();
        push  <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result consumer: random stall bursts, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_asks != hold_done) begin
      hold_done++;
      hold_left = HoldCycles;
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      pop <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 5);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // monitor: predict on every accepted byte, check every accepted result
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (push && !full) begin
        absorb_byte(req_i);
        byte_taken = 1'b1;
      end
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          $error("result with no frame pending: %h", result_o);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("verdict", want.verdict, result_o.verdict);
          check_field("transaction_id", want.transaction_id, result_o.transaction_id);
          check_field("protocol_id", want.protocol_id, result_o.protocol_id);
          check_field("length_value", want.length_value, result_o.length_value);
          check_field("unit_address", want.unit_address, result_o.unit_address);
          check_field("func_code", want.func_code, result_o.func_code);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned mark_bytes, mark_frames;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // count limits of the read and single write codes, at and just past the bound
    send_frame(16'h0001, 16'h0000, ReadLength, 8'h01, FcReadCoils, MaxBitCount, 8'h00, 12);
    send_frame(16'hFFFF, 16'hFFFF, ReadLength, 8'hFF, FcReadDiscrete, MaxBitCount + 16'd1,
               8'hFF, 12);
    send_frame(16'h0000, 16'h0000, ReadLength, 8'h00, FcReadDiscrete, 16'd0, 8'h00, 12);
    send_frame(16'h1234, 16'h0000, ReadLength, 8'h11, FcReadHolding, MaxRegCount, 8'h00, 12);
    send_frame(16'h5678, 16'h0000, ReadLength, 8'h22, FcReadInput, MaxRegCount + 16'd1,
               8'h00, 12);
    send_frame(16'h9ABC, 16'h0000, ReadLength, 8'h33, FcWriteCoil, MaxCoilValue, 8'h00, 12);
    send_frame(16'hDEF0, 16'h0000, ReadLength, 8'h44, FcWriteCoil, MaxCoilValue + 16'd1,
               8'h00, 12);
    send_frame(16'h0F0F, 16'h0000, ReadLength, 8'h55, FcWriteRegister, 16'hFFFF, 8'h00, 12);
    // bad length field, and a read with a byte too many
    send_frame(16'h0101, 16'h0000, 16'd7, 8'h01, FcReadHolding, 16'd1, 8'h00, 12);
    send_frame(16'h0202, 16'h0000, ReadLength, 8'h01, FcReadCoils, 16'd1, 8'h00, 13);
    // well-formed multiple writes, empty data and an odd register byte count too
    send_write(FcWriteCoils, 0);
    send_write(FcWriteCoils, 3);
    send_write(FcWriteRegisters, 4);
    send_write(FcWriteRegisters, 5);
    // multiple write failures one at a time
    send_frame(16'h0303, 16'h0000, ReadLength, 8'h01, FcWriteRegisters, 16'd0, 8'h00, 12);
    send_frame(16'h0404, 16'h0000, 16'd11, 8'h01, FcWriteCoils, 16'd3, 8'd3, 16);
    send_frame(16'h0505, 16'h0000, 16'd10, 8'h01, FcWriteCoils, 16'd3, 8'd4, 16);
    send_frame(16'h0606, 16'h0000, 16'd10, 8'h01, FcWriteCoils, 16'd2, 8'd3, 16);
    send_frame(16'h0707, 16'h0000, 16'd10, 8'h01, FcWriteRegisters, 16'd2, 8'd3, 16);
    // codes outside the supported set
    send_frame(16'h0808, 16'h0000, ReadLength, 8'h01, FcNone, 16'd1, 8'h00, 12);
    send_frame(16'h0909, 16'h0000, ReadLength, 8'h01, FcUnknown, 16'd1, 8'h00, 12);
    send_frame(16'h0A0A, 16'h0000, ReadLength, 8'h01, FcTop, 16'd1, 8'h00, 12);
    // short frames: missing header bytes read back as zero
    send_frame(16'hAAAA, 16'h5555, ReadLength, 8'h77, FcReadCoils, 16'd1, 8'h00, 1);
    send_frame(16'hAAAA, 16'h5555, ReadLength, 8'h77, FcReadCoils, 16'd1, 8'h00, 11);
    // too long frame: only the first FrameCap bytes count, the end mark still closes it
    send_frame(16'hBEEF, 16'h0000, 16'(FrameCap - 6), 8'h99, FcWriteRegisters, 16'd505,
               8'(FrameCap - 13), FrameCap + 6);
    wait_drained();

    // consumer holds off long enough for the block to fill and stall the request side
    hold_asks++;
    repeat (10) random_request();
    wait_drained();

    mark_bytes  = queued_bytes;
    mark_frames = queued_frames;
    while (queued_bytes - mark_bytes < 450 || queued_frames - mark_frames < 40)
      random_request();
    wait_drained();

    // last stretch at full rate on both sides
    quiet_tail = 1'b1;
    while (queued_bytes - mark_bytes < 550 || queued_frames - mark_frames < 48)
      random_request();
    wait_drained();
    repeat (TailPause) @(negedge clk_i);

    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
